// File: hdl/skbs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key search package
// Field widths, stream packing offsets, command codes and the command and
// status bundles shared by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package skbs_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 2048;

    localparam int KEY_LEN       = 6;
    localparam int CODE_W        = 21;
    localparam int STORED_CODE_W = 16;
    localparam int PAYLOAD_W     = 32;
    localparam int SLOT_W        = 11;
    localparam int COUNT_W       = 12;

    // Input tdata: entry_index, code_0 .. code_5, payload_in, zero fill.
    localparam int S_IDX_LSB     = 0;
    localparam int S_CODE_LSB    = S_IDX_LSB + SLOT_W;
    localparam int S_PAYLOAD_LSB = S_CODE_LSB + KEY_LEN * CODE_W;
    localparam int S_USED_W      = S_PAYLOAD_LSB + PAYLOAD_W;
    localparam int S_TDATA_W     = ((S_USED_W + 7) / 8) * 8;

    // Output tdata: payload_out, match_index, zero fill.
    localparam int M_USED_W      = PAYLOAD_W + SLOT_W;
    localparam int M_TDATA_W     = ((M_USED_W + 7) / 8) * 8;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_LOOKUP = 1'b1
    } cmd_t;

    localparam logic STATUS_FOUND = 1'b0;
    localparam logic STATUS_MISS  = 1'b1;

    typedef struct packed {
        logic load_wr;       // write the accepted entry into the table
        logic lookup_start;  // latch the key and issue the first probe
        logic step;          // evaluate the probe data and issue the next one
        logic emit;          // move the finished result into the output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic count_zero;    // the search range is empty
        logic done;          // the current probe ends the search
        logic out_busy;      // the output register holds an untaken result
    } dp_status_t;

endpackage
`default_nettype wire

// File: hdl/skbs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key search controller
// Sequences one item at a time: a load, a lookup through its
// probes and then the hand-off of the result to the output register.
// ----------------------------------------------------------------------------
module skbs_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic                 s_command,
    input  wire skbs_pkg::dp_status_t status,
    output skbs_pkg::ctrl_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_PROBE = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next       = state_reg;
        cmd              = '0;
        cmd.load_wr      = accept && (s_command == skbs_pkg::CMD_LOAD);
        cmd.lookup_start = accept && (s_command == skbs_pkg::CMD_LOOKUP);
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.lookup_start) begin
                    state_next = status.count_zero ? ST_EMIT : ST_PROBE;
                end
            end
            ST_PROBE: begin
                cmd.step = 1'b1;
                if (status.done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                cmd.emit = !status.out_busy;
                if (!status.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // A result must never overwrite one that the consumer has not taken yet.
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !status.out_busy)
        else $error("result emitted into a busy output register");

    // A lookup whose search range is empty produces its miss right away.
    a_empty_skips_probe: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.lookup_start && status.count_zero) |=> (state_reg == ST_EMIT))
        else $error("empty lookup entered the probe loop");

endmodule
`default_nettype wire

// File: hdl/skbs_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key search datapath
// Holds the entry table, the entry count register, the lookup key, the
// search bounds, the key comparator and the output register.
// ----------------------------------------------------------------------------
module skbs_dp #(
    parameter int TABLE_DEPTH = skbs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [skbs_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic                              cfg_we,
    input  wire logic [skbs_pkg::COUNT_W-1:0]      cfg_wdata,
    input  wire skbs_pkg::ctrl_cmd_t               cmd,
    output skbs_pkg::dp_status_t                   status,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [skbs_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic                                   m_tuser
);

    localparam int AW      = $clog2(TABLE_DEPTH);
    localparam int CW      = AW + 1;
    localparam int XW      = (CW > skbs_pkg::COUNT_W) ? CW : skbs_pkg::COUNT_W;
    localparam int KEY_W   = skbs_pkg::KEY_LEN * skbs_pkg::STORED_CODE_W;
    localparam int ENTRY_W = KEY_W + skbs_pkg::PAYLOAD_W;
    localparam int PAD_W   = skbs_pkg::M_TDATA_W - skbs_pkg::M_USED_W;

    logic [ENTRY_W-1:0] table_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic [skbs_pkg::COUNT_W-1:0] entries_in_use_reg;
    logic [skbs_pkg::CODE_W-1:0]  key_reg [skbs_pkg::KEY_LEN];
    logic [CW-1:0]                lo_reg;
    logic [CW-1:0]                lo_next;
    logic [CW-1:0]                hi_reg;
    logic [CW-1:0]                hi_next;
    logic [AW-1:0]                mid_reg;
    logic [AW-1:0]                rd_addr;

    logic                           res_miss_reg;
    logic [skbs_pkg::PAYLOAD_W-1:0] res_payload_reg;
    logic [skbs_pkg::SLOT_W-1:0]    res_index_reg;
    logic                           m_tvalid_reg;
    logic                           m_miss_reg;
    logic [skbs_pkg::PAYLOAD_W-1:0] m_payload_reg;
    logic [skbs_pkg::SLOT_W-1:0]    m_index_reg;

    logic [skbs_pkg::SLOT_W-1:0]    in_index;
    logic [skbs_pkg::PAYLOAD_W-1:0] in_payload;
    logic [ENTRY_W-1:0]             wr_entry;
    logic                           wr_en;

    logic [XW-1:0] cfg_ext;
    logic [XW-1:0] count_x;
    logic [CW-1:0] count;
    logic [CW-1:0] hi_first;
    logic [AW-1:0] mid_first;

    logic [skbs_pkg::KEY_LEN-1:0] el_gt;
    logic [skbs_pkg::KEY_LEN-1:0] el_lt;
    logic                         cmp_gt;
    logic                         cmp_lt;
    logic                         cmp_eq;
    logic                         decided;

    logic [CW-1:0] lo_gt;
    logic [CW-1:0] hi_lt;
    logic [CW:0]   sum_gt;
    logic [CW:0]   sum_lt;
    logic [AW-1:0] mid_gt;
    logic [AW-1:0] mid_lt;
    logic          miss_gt;
    logic          miss_lt;

    // ------------------------------------------------------------------
    // Load path: only the low 16 bits of each code are stored.
    // ------------------------------------------------------------------
    assign in_index   = s_tdata[skbs_pkg::S_IDX_LSB +: skbs_pkg::SLOT_W];
    assign in_payload = s_tdata[skbs_pkg::S_PAYLOAD_LSB +: skbs_pkg::PAYLOAD_W];

    always_comb begin
        wr_entry = '0;
        for (int i = 0; i < skbs_pkg::KEY_LEN; i++) begin
            wr_entry[i*skbs_pkg::STORED_CODE_W +: skbs_pkg::STORED_CODE_W] =
                s_tdata[skbs_pkg::S_CODE_LSB + i*skbs_pkg::CODE_W +: skbs_pkg::STORED_CODE_W];
        end
        wr_entry[KEY_W +: skbs_pkg::PAYLOAD_W] = in_payload;
    end

    assign wr_en = cmd.load_wr && (32'(in_index) < 32'(TABLE_DEPTH));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[AW'(in_index)] <= wr_entry;
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Entry count, clamped to the table depth.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_in_use_reg <= '0;
        end else if (cfg_we) begin
            entries_in_use_reg <= cfg_wdata;
        end
    end

    assign cfg_ext   = XW'(entries_in_use_reg);
    assign count_x   = (cfg_ext > XW'(TABLE_DEPTH)) ? XW'(TABLE_DEPTH) : cfg_ext;
    assign count     = CW'(count_x);
    assign hi_first  = count - CW'(1);
    assign mid_first = AW'(hi_first >> 1);

    // ------------------------------------------------------------------
    // Key comparison: the first differing element decides.
    // ------------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < skbs_pkg::KEY_LEN; i++) begin
            el_gt[i] = key_reg[i] > skbs_pkg::CODE_W'(
                rd_data_reg[i*skbs_pkg::STORED_CODE_W +: skbs_pkg::STORED_CODE_W]);
            el_lt[i] = key_reg[i] < skbs_pkg::CODE_W'(
                rd_data_reg[i*skbs_pkg::STORED_CODE_W +: skbs_pkg::STORED_CODE_W]);
        end
    end

    always_comb begin
        cmp_gt  = 1'b0;
        cmp_lt  = 1'b0;
        decided = 1'b0;
        for (int i = 0; i < skbs_pkg::KEY_LEN; i++) begin
            if (!decided && (el_gt[i] || el_lt[i])) begin
                cmp_gt  = el_gt[i];
                cmp_lt  = el_lt[i];
                decided = 1'b1;
            end
        end
        cmp_eq = !decided;
    end

    // ------------------------------------------------------------------
    // Both possible next probes are formed alongside the compare, so the
    // compare outcome only selects the next read address.
    // ------------------------------------------------------------------
    assign lo_gt   = CW'(mid_reg) + CW'(1);
    assign hi_lt   = CW'(mid_reg) - CW'(1);
    assign sum_gt  = {1'b0, lo_gt} + {1'b0, hi_reg};
    assign sum_lt  = {1'b0, lo_reg} + {1'b0, hi_lt};
    assign mid_gt  = AW'(sum_gt >> 1);
    assign mid_lt  = AW'(sum_lt >> 1);
    assign miss_gt = lo_gt > hi_reg;
    assign miss_lt = (mid_reg == '0) || (lo_reg > hi_lt);

    always_comb begin
        rd_addr = mid_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        priority if (cmd.lookup_start) begin
            rd_addr = mid_first;
            lo_next = '0;
            hi_next = hi_first;
        end else if (cmd.step && cmp_gt) begin
            rd_addr = mid_gt;
            lo_next = lo_gt;
        end else if (cmd.step && cmp_lt) begin
            rd_addr = mid_lt;
            hi_next = hi_lt;
        end
    end

    always_ff @(posedge aclk) begin
        mid_reg <= rd_addr;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        if (cmd.lookup_start) begin
            for (int i = 0; i < skbs_pkg::KEY_LEN; i++) begin
                key_reg[i] <= s_tdata[skbs_pkg::S_CODE_LSB + i*skbs_pkg::CODE_W +:
                                      skbs_pkg::CODE_W];
            end
        end
    end

    assign status.count_zero = (count == '0);
    assign status.done       = cmp_eq || (cmp_gt ? miss_gt : miss_lt);
    assign status.out_busy   = m_tvalid_reg && !m_tready;

    // ------------------------------------------------------------------
    // Result holding register and output register.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (cmd.lookup_start) begin
            res_miss_reg    <= skbs_pkg::STATUS_MISS;
            res_payload_reg <= '0;
            res_index_reg   <= '0;
        end else if (cmd.step && cmp_eq) begin
            res_miss_reg    <= skbs_pkg::STATUS_FOUND;
            res_payload_reg <= rd_data_reg[KEY_W +: skbs_pkg::PAYLOAD_W];
            res_index_reg   <= skbs_pkg::SLOT_W'(mid_reg);
        end
        if (cmd.emit) begin
            m_miss_reg    <= res_miss_reg;
            m_payload_reg <= res_payload_reg;
            m_index_reg   <= res_index_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_miss_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_index_reg, m_payload_reg};

    // Every probe lies inside the current inclusive bounds.
    a_probe_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> (lo_reg <= CW'(mid_reg)) && (CW'(mid_reg) <= hi_reg))
        else $error("probe address outside the search bounds");

    // A step that does not end the search leaves a non-empty range.
    a_range_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && !status.done) |=> (lo_reg <= hi_reg))
        else $error("search continued over an empty range");

endmodule
`default_nettype wire

// File: hdl/sorted_key_binary_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key binary search
// Table of sorted six-element keys with payload offsets, loaded one entry
// per item and searched by binary search on lookup items.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Carries
//  s_        in         s_tvalid / s_tready    load or lookup item
//  m_        out        m_tvalid / m_tready    lookup result
//  cfg_w     in         cfg_wvalid/cfg_wready  entries_in_use
//
//  A load is written into the table as it is accepted. A lookup is
//  accepted, probes the table memory (at most floor(log2(entries_in_use))
//  + 1 probes, so 12 for a full table of 2048), then fills the output register.
//  The single read port of the entry table sets the one-probe-per-cycle pace.
//  Reset clears the controller, the entry count and the output valid; the
//  table itself is not cleared. A stalled result holds the controller in its
//  hand-off state until the output register frees up.
// ----------------------------------------------------------------------------
module sorted_key_binary_search #(
    parameter int TABLE_DEPTH = skbs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // entry_index, code_0 .. code_5, payload_in, zero fill
    input  wire logic [skbs_pkg::S_TDATA_W-1:0]  s_tdata,
    // command
    input  wire logic                            s_tuser,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // payload_out, match_index, zero fill
    output logic [skbs_pkg::M_TDATA_W-1:0]       m_tdata,
    // status
    output logic                                 m_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [skbs_pkg::COUNT_W-1:0]    cfg_wdata,
    input  wire logic                            cfg_wvalid,
    output logic                                 cfg_wready
);

    skbs_pkg::ctrl_cmd_t  cmd;
    skbs_pkg::dp_status_t status;

    // The count register takes a write in any cycle.
    assign cfg_wready = 1'b1;

    skbs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_command (s_tuser),
        .status    (status),
        .cmd       (cmd)
    );

    skbs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_wvalid && cfg_wready),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire
